// ===== design/ibpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ibpr_pkg
// Shared types and constants of the isolated black pixel removal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibpr_pkg;

	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DEPTH  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic FUNC_FLUSH = 1'b1;

	localparam logic [7:0] PIX_BLACK = 8'd0;
	localparam logic [7:0] PIX_WHITE = 8'd255;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	typedef struct packed {
		logic       func;
		logic [7:0] pixel_in;
	} ibpr_in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_end;
	} ibpr_out_t;

	// per-item control carried from the counter stage to the line buffer
	typedef struct packed {
		logic       emit;
		logic       interior;
		logic       frame_end;
		logic [7:0] val;
	} ibpr_tag_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_CLAMP,
		SEQ_MUL,
		SEQ_DIV
	} ibpr_seq_t;

endpackage

`default_nettype wire

// ===== design/ibpr_div.sv =====
// ----------------------------------------------------------------------------
// ibpr_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpr_div #(
	parameter int TW = 27,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [TW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [TW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);

	localparam int CNTW = $clog2(TW + 1);

	logic [TW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, quo_q[TW-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			cnt_q  <= CNTW'(TW);
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNTW'(1));
			if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= DW'(rem_sh - {1'b0, div_q});
			end else begin
				rem_q <= rem_sh[DW-1:0];
			end
			quo_q <= {quo_q[TW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== design/ibpr_line_buf.sv =====
// ----------------------------------------------------------------------------
// ibpr_line_buf
// Two-row line memory with read-modify-write, 3x3 window and isolation test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpr_line_buf #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] item_col,
	input  wire ibpr_pkg::ibpr_tag_t          item_tag,
	output logic                              res_push,
	output ibpr_pkg::ibpr_out_t               res
);

	import ibpr_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	typedef struct packed {
		logic [7:0] upper;
		logic [7:0] middle;
	} entry_t;

	entry_t         mem [MAX_WIDTH];
	entry_t         rd_q;
	logic           s1_valid_q;
	logic [CW-1:0]  col_s1;
	ibpr_tag_t      tag_s1;
	logic           fwd_s1;
	entry_t         fwd_data_s1;
	logic [7:0]     win_q [9];
	entry_t         entry_s1;
	entry_t         wr_entry;
	logic [7:0]     nw [9];
	logic           iso;

	// read at accept, data lands with the item in stage 1
	always_ff @(posedge clk) begin
		if (item_valid) begin
			rd_q <= mem[item_col];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			mem[col_s1] <= wr_entry;
		end
	end

	// same column back to back (one-pixel rows): take the pending write
	assign entry_s1        = fwd_s1 ? fwd_data_s1 : rd_q;
	assign wr_entry.upper  = entry_s1.middle;
	assign wr_entry.middle = tag_s1.val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			s1_valid_q <= item_valid;
			fwd_s1     <= item_valid && s1_valid_q && (item_col == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid) begin
			col_s1      <= item_col;
			tag_s1      <= item_tag;
			fwd_data_s1 <= wr_entry;
		end
	end

	always_comb begin
		nw[0] = win_q[1];
		nw[1] = win_q[2];
		nw[2] = entry_s1.upper;
		nw[3] = win_q[4];
		nw[4] = win_q[5];
		nw[5] = entry_s1.middle;
		nw[6] = win_q[7];
		nw[7] = win_q[8];
		nw[8] = tag_s1.val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= PIX_BLACK;
			end
		end else if (s1_valid_q) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= nw[i];
			end
		end
	end

	always_comb begin
		iso = (nw[4] == PIX_BLACK);
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && nw[k] != PIX_WHITE) begin
				iso = 1'b0;
			end
		end
	end

	assign res_push      = s1_valid_q && tag_s1.emit;
	assign res.pixel_out = (tag_s1.interior && iso) ? PIX_WHITE : nw[4];
	assign res.frame_end = tag_s1.frame_end;

endmodule

`default_nettype wire

// ===== design/ibpr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ibpr_out_fifo
// Small result queue that decouples the output handshake from the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibpr_out_fifo (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	input  wire ibpr_pkg::ibpr_out_t                    push_data,
	output logic                                        valid,
	input  wire logic                                   ready,
	output ibpr_pkg::ibpr_out_t                         data,
	output logic [$clog2(ibpr_pkg::OUT_DEPTH + 1)-1:0] count
);

	import ibpr_pkg::*;

	localparam int PW   = $clog2(OUT_DEPTH);
	localparam int CNTW = $clog2(OUT_DEPTH + 1);

	ibpr_out_t       slot_q [OUT_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            pop;

	assign valid = cnt_q != '0;
	assign pop   = valid && ready;
	assign data  = slot_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== design/isolated_black_pixel_removal.sv =====
// ----------------------------------------------------------------------------
// isolated_black_pixel_removal
// Streams 8-bit pixels in raster order and returns each pixel one row and one
// pixel later; a black interior pixel (0) whose eight neighbours are all white
// (255) comes out white, everything else and the outer ring pass unchanged.
// One transaction is taken per clock unless a geometry rebuild or a full
// result queue holds pix_ready low: the two previous rows sit in a single
// line memory that is read when a pixel is taken and written back the next
// cycle, so a pixel can enter every cycle and results leave through a small
// queue. Flush transactions after the last pixel push out the frame_width + 1
// pixels still held; frame_end marks the last pixel of a frame. After each
// configuration write the block rebuilds its frame geometry and takes no pixel
// during that time. The line memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isolated_black_pixel_removal #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pix_valid,
	output logic                                     pix_ready,
	input  wire ibpr_pkg::ibpr_in_t                  pix_data,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output ibpr_pkg::ibpr_out_t                      res_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ibpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ibpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import ibpr_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WEW   = CW + 1;
	localparam int TW    = WEW + FH_W;
	localparam int CMPW  = (WEW > FW_W) ? WEW : FW_W;
	localparam int CNTW  = $clog2(OUT_DEPTH + 1);
	localparam int W_RST = (int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH
		: int'(FRAME_WIDTH_RST);
	localparam int H_RST = int'(FRAME_HEIGHT_RST);

	// configuration and derived geometry
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [WEW-1:0]  w_q;
	logic [FH_W-1:0] h_q;
	logic [TW-1:0]   total_q;
	logic [WEW-1:0]  w_m2_q;
	logic [FH_W-1:0] h_m2_q;
	logic            small_q;

	ibpr_seq_t seq_q;
	ibpr_seq_t seq_d;
	logic      ld_clamp;
	logic      ld_mul;
	logic      div_start;
	logic      seq_take;
	logic      busy;

	logic [CMPW-1:0] fw_ext;
	logic [WEW-1:0]  w_clamp;
	logic [FH_W-1:0] h_clamp;
	logic [TW-1:0]   product;

	logic          div_done;
	logic [TW-1:0] div_quo;
	logic [WEW-1:0] div_rem;

	// stream position
	logic [CW-1:0] col_q;
	logic [TW-1:0] row_q;
	logic [TW-1:0] emit_cnt_q;
	logic [TW-1:0] orow_q;
	logic [CW-1:0] ocol_q;
	logic          inflight_q;

	logic          cfg_acc;
	logic          pix_acc;
	logic          abandon;
	logic [CW-1:0] col_c;
	logic [TW-1:0] row_c;
	logic [TW-1:0] emit_c;
	logic [TW-1:0] orow_c;
	logic [CW-1:0] ocol_c;
	logic          in_frame;
	logic          ignore;
	logic          emit;
	logic          interior;
	logic          last;
	logic [WEW-1:0] col_inc;
	logic [WEW-1:0] ocol_inc;
	logic          col_wrap;
	logic          ocol_wrap;
	logic [CW-1:0] col_n;
	logic [TW-1:0] row_n;
	logic [TW-1:0] emit_n;
	logic [TW-1:0] orow_n;
	logic [CW-1:0] ocol_n;

	ibpr_tag_t     item_tag;
	logic          item_valid;
	logic          res_push;
	ibpr_out_t     res_word;
	logic [CNTW-1:0] fifo_cnt;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign pix_ready = !busy && ((CNTW'(fifo_cnt) + CNTW'(inflight_q)) < CNTW'(OUT_DEPTH));
	assign pix_acc   = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// geometry rebuild: clamp, multiply, then divide the output position
	always_comb begin
		seq_d = seq_q;
		if (cfg_acc) begin
			seq_d = SEQ_CLAMP;
		end else begin
			case (seq_q)
				SEQ_IDLE:  seq_d = SEQ_IDLE;
				SEQ_CLAMP: seq_d = SEQ_MUL;
				SEQ_MUL:   seq_d = SEQ_DIV;
				SEQ_DIV: begin
					if (div_done) begin
						seq_d = SEQ_IDLE;
					end
				end
				default:   seq_d = SEQ_IDLE;
			endcase
		end
	end

	always_comb begin
		ld_clamp  = 1'b0;
		ld_mul    = 1'b0;
		div_start = 1'b0;
		seq_take  = 1'b0;
		busy      = 1'b1;
		case (seq_q)
			SEQ_IDLE:  busy = 1'b0;
			SEQ_CLAMP: ld_clamp = 1'b1;
			SEQ_MUL: begin
				ld_mul    = 1'b1;
				div_start = 1'b1;
			end
			SEQ_DIV:   seq_take = div_done;
			default:   busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_comb begin
		fw_ext = CMPW'(frame_width_q);
		if (fw_ext == '0) begin
			w_clamp = WEW'(1);
		end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
			w_clamp = WEW'(MAX_WIDTH);
		end else begin
			w_clamp = WEW'(frame_width_q);
		end
		h_clamp = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end

	assign product = TW'(w_q) * TW'(h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= WEW'(W_RST);
			h_q     <= FH_W'(H_RST);
			total_q <= TW'(W_RST * H_RST);
			w_m2_q  <= WEW'(W_RST - 2);
			h_m2_q  <= FH_W'(H_RST - 2);
			small_q <= (W_RST < 3);
		end else begin
			if (ld_clamp) begin
				w_q <= w_clamp;
				h_q <= h_clamp;
			end
			if (ld_mul) begin
				total_q <= product;
				w_m2_q  <= w_q - WEW'(2);
				h_m2_q  <= h_q - FH_W'(2);
				small_q <= (w_q < WEW'(3)) || (h_q < FH_W'(3));
			end
		end
	end

	ibpr_div #(
		.TW (TW),
		.DW (WEW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (emit_cnt_q),
		.divisor   (w_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// position bookkeeping for the transaction being taken
	always_comb begin
		abandon = (emit_cnt_q >= total_q) || (WEW'(col_q) >= w_q);
		if (abandon) begin
			col_c  = '0;
			row_c  = '0;
			emit_c = '0;
			orow_c = '0;
			ocol_c = '0;
		end else begin
			col_c  = col_q;
			row_c  = row_q;
			emit_c = emit_cnt_q;
			orow_c = orow_q;
			ocol_c = ocol_q;
		end

		in_frame = row_c < TW'(h_q);
		ignore   = in_frame && (pix_data.func == FUNC_FLUSH);
		emit     = !((row_c == '0) || ((row_c == TW'(1)) && (col_c == '0)));
		interior = !small_q && (orow_c != '0) && (orow_c <= TW'(h_m2_q))
			&& (ocol_c != '0) && (WEW'(ocol_c) <= w_m2_q);
		last     = emit_c == (total_q - TW'(1));

		col_inc   = WEW'(col_c) + WEW'(1);
		col_wrap  = col_inc >= w_q;
		ocol_inc  = WEW'(ocol_c) + WEW'(1);
		ocol_wrap = ocol_inc >= w_q;

		col_n  = col_wrap ? '0 : col_inc[CW-1:0];
		row_n  = col_wrap ? row_c + TW'(1) : row_c;
		emit_n = emit_c;
		orow_n = orow_c;
		ocol_n = ocol_c;
		if (ignore) begin
			col_n = col_c;
			row_n = row_c;
		end else if (emit) begin
			if (last) begin
				col_n  = '0;
				row_n  = '0;
				emit_n = '0;
				orow_n = '0;
				ocol_n = '0;
			end else begin
				emit_n = emit_c + TW'(1);
				ocol_n = ocol_wrap ? '0 : ocol_inc[CW-1:0];
				orow_n = ocol_wrap ? orow_c + TW'(1) : orow_c;
			end
		end

		item_tag.emit      = emit;
		item_tag.interior  = interior;
		item_tag.frame_end = last;
		item_tag.val       = in_frame ? pix_data.pixel_in : PIX_BLACK;
	end

	assign item_valid = pix_acc && !ignore;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			emit_cnt_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			inflight_q <= 1'b0;
		end else begin
			inflight_q <= item_valid && emit;
			if (pix_acc) begin
				col_q      <= col_n;
				row_q      <= row_n;
				emit_cnt_q <= emit_n;
				orow_q     <= orow_n;
				ocol_q     <= ocol_n;
			end else if (seq_take) begin
				orow_q <= div_quo;
				ocol_q <= div_rem[CW-1:0];
			end
		end
	end

	ibpr_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_col   (col_c),
		.item_tag   (item_tag),
		.res_push   (res_push),
		.res        (res_word)
	);

	ibpr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_word),
		.valid     (res_valid),
		.ready     (res_ready),
		.data      (res_data),
		.count     (fifo_cnt)
	);

endmodule

`default_nettype wire
